// ----- rtl/core/vrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_pkg
// Shared types and constants for the velocity to RC channel frame encoder.
// ----------------------------------------------------------------------------
package vrc_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CH_BITS       = 11;
    localparam int FRAME_BITS    = CHANNEL_COUNT * CH_BITS;
    localparam int SPEED_BITS    = 32;
    localparam int GAIN_BITS     = 16;
    localparam int PROD_BITS     = SPEED_BITS + GAIN_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FLAG_BYTE   = 8'h00;

    // byte positions within a frame
    localparam logic [4:0] HEADER_INDEX = 5'd0;
    localparam logic [4:0] DATA_LAST    = 5'd22;
    localparam logic [4:0] FLAG_INDEX   = 5'd23;
    localparam logic [4:0] SUM_INDEX    = 5'd24;

    localparam logic [CH_BITS-1:0] CENTER_RESET = 11'd1500;
    localparam logic [CH_BITS-1:0] LOW_RESET    = 11'd1050;
    localparam logic [CH_BITS-1:0] HIGH_RESET   = 11'd1950;
    localparam logic [CH_BITS-1:0] CHAN_RESET   = 11'd1500;
    localparam logic [GAIN_BITS-1:0] LIN_GAIN_RESET   = 16'd23000;
    localparam logic [GAIN_BITS-1:0] LEFT_GAIN_RESET  = 16'd30000;
    localparam logic [GAIN_BITS-1:0] RIGHT_GAIN_RESET = 16'd40000;
    localparam logic [GAIN_BITS-1:0] DEAD_BAND_RESET  = 16'd65;

    typedef enum logic {
        CMD_SET_VEL = 1'b0,
        CMD_SEND    = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CENTER     = 3'd0,
        REG_LOW_LIMIT  = 3'd1,
        REG_HIGH_LIMIT = 3'd2,
        REG_LIN_GAIN   = 3'd3,
        REG_LEFT_GAIN  = 3'd4,
        REG_RIGHT_GAIN = 3'd5,
        REG_DEAD_BAND  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CH_BITS-1:0]   center;
        logic [CH_BITS-1:0]   low_limit;
        logic [CH_BITS-1:0]   high_limit;
        logic [GAIN_BITS-1:0] lin_gain;
        logic [GAIN_BITS-1:0] left_gain;
        logic [GAIN_BITS-1:0] right_gain;
        logic [GAIN_BITS-1:0] dead_band;
    } cfg_t;

    // one classified command word
    typedef struct packed {
        cmd_t                  cmd;
        logic                  lin_neg;
        logic                  lin_dead;
        logic [SPEED_BITS-1:0] lin_mag;
        logic                  ang_neg;
        logic                  ang_dead;
        logic [SPEED_BITS-1:0] ang_mag;
    } item_t;

endpackage

// ----- rtl/core/vrc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_front
// Input stage: takes command words, splits speeds into sign and magnitude,
// flags deadband hits, and hands classified words to the command queue.
// ----------------------------------------------------------------------------
module vrc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              cmd,
    input  logic signed [vrc_pkg::SPEED_BITS-1:0] linear_speed,
    input  logic signed [vrc_pkg::SPEED_BITS-1:0] turn_rate,
    input  vrc_pkg::cfg_t                     cfg,
    output logic                              q_push,
    output vrc_pkg::item_t                    q_item,
    input  logic                              q_full
);
    import vrc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    function automatic logic [SPEED_BITS:0] classify(
        input logic [SPEED_BITS-1:0] raw,
        input logic [GAIN_BITS-1:0]  band
    );
        logic [SPEED_BITS-1:0] mag;
        logic                  dead;
        mag  = raw[SPEED_BITS-1] ? (~raw + 1'b1) : raw;
        dead = (mag <= {{(SPEED_BITS-GAIN_BITS){1'b0}}, band});
        return {dead, mag};
    endfunction

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    always_comb
    begin
        logic [SPEED_BITS:0] lin_c;
        logic [SPEED_BITS:0] ang_c;
        lin_c = classify(linear_speed, cfg.dead_band);
        ang_c = classify(turn_rate, cfg.dead_band);
        item_next.cmd      = cmd_t'(cmd);
        item_next.lin_neg  = linear_speed[SPEED_BITS-1];
        item_next.lin_dead = lin_c[SPEED_BITS];
        item_next.lin_mag  = lin_c[SPEED_BITS-1:0];
        item_next.ang_neg  = turn_rate[SPEED_BITS-1];
        item_next.ang_dead = ang_c[SPEED_BITS];
        item_next.ang_mag  = ang_c[SPEED_BITS-1:0];
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/core/vrc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_queue
// Short command queue between the input stage and the executor.
// ----------------------------------------------------------------------------
module vrc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  vrc_pkg::item_t wr_item,
    output logic           q_full,
    output logic           rd_valid,
    output vrc_pkg::item_t rd_item,
    input  logic           rd_en
);
    import vrc_pkg::*;

    item_t                store_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign q_full   = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/core/vrc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_back
// Executor: turns set-velocity words into channel values through one shared
// multiplier, and streams 25-byte frames into the result register.
// ----------------------------------------------------------------------------
module vrc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  vrc_pkg::cfg_t  cfg,
    input  logic           rd_valid,
    input  vrc_pkg::item_t rd_item,
    output logic           rd_en,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     frame_byte,
    output logic [4:0]     byte_index,
    output logic           last
);
    import vrc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN_MUL,
        ST_LIN_SET,
        ST_ANG_SET,
        ST_SEND
    } state_t;

    state_t               state_reg;
    item_t                item_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [CH_BITS-1:0]   chan_reg [CHANNEL_COUNT];
    logic [FRAME_BITS-1:0] bits_reg;
    logic [FRAME_BITS-1:0] bits_packed;
    logic [4:0]           idx_reg;
    logic [7:0]           sum_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           byte_reg;
    logic [4:0]           index_reg;
    logic                 last_reg;

    logic                 out_free;
    logic [7:0]           byte_next;
    logic [SPEED_BITS-1:0] counts;
    logic [CH_BITS-1:0]   lin_chan;
    logic [CH_BITS-1:0]   ang_chan;
    logic [GAIN_BITS-1:0] ang_gain;

    function automatic logic [CH_BITS-1:0] speed_to_chan(
        input logic                  neg,
        input logic                  dead,
        input logic [SPEED_BITS-1:0] cnt,
        input cfg_t                  c
    );
        logic [SPEED_BITS:0] up;
        logic [CH_BITS-1:0]  down;
        up   = {{(SPEED_BITS-CH_BITS+1){1'b0}}, c.center} + {1'b0, cnt};
        down = c.center - cnt[CH_BITS-1:0];
        if (dead)
        begin
            return c.center;
        end
        else if (!neg)
        begin
            // product at or above center wraps below zero: clamp low
            if ((cnt >= {{(SPEED_BITS-CH_BITS){1'b0}}, c.center}) || (down <= c.low_limit))
            begin
                return c.low_limit;
            end
            return down;
        end
        else
        begin
            if (up >= {{(SPEED_BITS-CH_BITS+1){1'b0}}, c.high_limit})
            begin
                return c.high_limit;
            end
            return up[CH_BITS-1:0];
        end
    endfunction

    assign out_free   = !out_valid_reg || pop;
    assign rd_en      = (state_reg == ST_IDLE) && rd_valid;
    assign empty      = !out_valid_reg;
    assign frame_byte = byte_reg;
    assign byte_index = index_reg;
    assign last       = last_reg;

    assign counts   = prod_reg[PROD_BITS-1:GAIN_BITS];
    assign lin_chan = speed_to_chan(item_reg.lin_neg, item_reg.lin_dead, counts, cfg);
    assign ang_chan = speed_to_chan(item_reg.ang_neg, item_reg.ang_dead, counts, cfg);
    assign ang_gain = item_reg.ang_neg ? cfg.right_gain : cfg.left_gain;

    // channel 0 leads the stream, each channel MSB first
    always_comb
    begin
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            bits_packed[FRAME_BITS-1-CH_BITS*i -: CH_BITS] = chan_reg[i];
        end
    end

    always_comb
    begin
        if (idx_reg == HEADER_INDEX)
        begin
            byte_next = HEADER_BYTE;
        end
        else if (idx_reg <= DATA_LAST)
        begin
            byte_next = bits_reg[FRAME_BITS-1 -: 8];
        end
        else if (idx_reg == FLAG_INDEX)
        begin
            byte_next = FLAG_BYTE;
        end
        else
        begin
            byte_next = sum_reg;
        end
    end

    // drop the word on pop, load a new one when the frame advances
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_SEND) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            byte_reg      <= '0;
            index_reg     <= '0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                chan_reg[i] <= CHAN_RESET;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rd_valid)
                    begin
                        if (rd_item.cmd == CMD_SEND)
                        begin
                            idx_reg   <= HEADER_INDEX;
                            sum_reg   <= '0;
                            state_reg <= ST_SEND;
                        end
                        else
                        begin
                            state_reg <= ST_LIN_MUL;
                        end
                    end
                end
                ST_LIN_MUL:
                begin
                    state_reg <= ST_LIN_SET;
                end
                ST_LIN_SET:
                begin
                    chan_reg[1] <= lin_chan;
                    state_reg   <= ST_ANG_SET;
                end
                ST_ANG_SET:
                begin
                    chan_reg[0] <= ang_chan;
                    state_reg   <= ST_IDLE;
                end
                ST_SEND:
                begin
                    if (out_free)
                    begin
                        byte_reg  <= byte_next;
                        index_reg <= idx_reg;
                        last_reg  <= (idx_reg == SUM_INDEX);
                        if (idx_reg == SUM_INDEX)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + byte_next;
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && rd_valid)
        begin
            item_reg <= rd_item;
            bits_reg <= bits_packed;
        end
        if (state_reg == ST_LIN_MUL)
        begin
            prod_reg <= item_reg.lin_mag * cfg.lin_gain;
        end
        else if (state_reg == ST_LIN_SET)
        begin
            prod_reg <= item_reg.ang_mag * ang_gain;
        end
        if ((state_reg == ST_SEND) && out_free && (idx_reg != HEADER_INDEX))
        begin
            bits_reg <= bits_reg << 8;
        end
    end

endmodule

// ----- rtl/core/velocity_to_rc_channel_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_to_rc_channel_frame
// Holds 16 RC channels, maps velocity commands onto channels 0 and 1, and
// emits 25-byte channel frames one byte per word.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  command   | in        | push / full            | cmd, linear_speed, turn_rate
//  frame     | out       | pop / empty            | frame_byte, byte_index, last
//  config    | in        | psel/penable/pready    | paddr, pwdata, prdata
//
//  A set-velocity word in the executor goes through dispatch, then one
//  pass each through the shared 32x16 multiplier for linear and turn speed.
//  A send word: dispatch, then 25 bytes at one per cycle unless the output
//  stalls, bound by the single result register. The input stage and a 2-deep
//  command queue keep taking words while the executor is busy or the output
//  stalls. Reset clears all handshake state and sets every channel to 1500.
// ----------------------------------------------------------------------------
module velocity_to_rc_channel_frame (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vrc_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [vrc_pkg::DATA_BITS-1:0]         pwdata,
    output logic [vrc_pkg::DATA_BITS-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  cmd,
    input  logic signed [vrc_pkg::SPEED_BITS-1:0] linear_speed,
    input  logic signed [vrc_pkg::SPEED_BITS-1:0] turn_rate,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [7:0]                            frame_byte,
    output logic [4:0]                            byte_index,
    output logic                                  last
);
    import vrc_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_wr;
    reg_idx_t reg_sel;
    logic     q_push;
    item_t    q_item;
    logic     q_full;
    logic     rd_valid;
    item_t    rd_item;
    logic     rd_en;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center     <= CENTER_RESET;
            cfg_reg.low_limit  <= LOW_RESET;
            cfg_reg.high_limit <= HIGH_RESET;
            cfg_reg.lin_gain   <= LIN_GAIN_RESET;
            cfg_reg.left_gain  <= LEFT_GAIN_RESET;
            cfg_reg.right_gain <= RIGHT_GAIN_RESET;
            cfg_reg.dead_band  <= DEAD_BAND_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_CENTER:     cfg_reg.center     <= pwdata[CH_BITS-1:0];
                REG_LOW_LIMIT:  cfg_reg.low_limit  <= pwdata[CH_BITS-1:0];
                REG_HIGH_LIMIT: cfg_reg.high_limit <= pwdata[CH_BITS-1:0];
                REG_LIN_GAIN:   cfg_reg.lin_gain   <= pwdata[GAIN_BITS-1:0];
                REG_LEFT_GAIN:  cfg_reg.left_gain  <= pwdata[GAIN_BITS-1:0];
                REG_RIGHT_GAIN: cfg_reg.right_gain <= pwdata[GAIN_BITS-1:0];
                REG_DEAD_BAND:  cfg_reg.dead_band  <= pwdata[GAIN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CENTER:     prdata = DATA_BITS'(cfg_reg.center);
            REG_LOW_LIMIT:  prdata = DATA_BITS'(cfg_reg.low_limit);
            REG_HIGH_LIMIT: prdata = DATA_BITS'(cfg_reg.high_limit);
            REG_LIN_GAIN:   prdata = DATA_BITS'(cfg_reg.lin_gain);
            REG_LEFT_GAIN:  prdata = DATA_BITS'(cfg_reg.left_gain);
            REG_RIGHT_GAIN: prdata = DATA_BITS'(cfg_reg.right_gain);
            REG_DEAD_BAND:  prdata = DATA_BITS'(cfg_reg.dead_band);
            default:        prdata = '0;
        endcase
    end

    vrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .cfg          (cfg_reg),
        .q_push       (q_push),
        .q_item       (q_item),
        .q_full       (q_full)
    );

    vrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_item  (q_item),
        .q_full   (q_full),
        .rd_valid (rd_valid),
        .rd_item  (rd_item),
        .rd_en    (rd_en)
    );

    vrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rd_valid   (rd_valid),
        .rd_item    (rd_item),
        .rd_en      (rd_en),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last       (last)
    );

endmodule

// ----- rtl/core/vrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_checker
// Port-level checks on the frame stream of the channel frame encoder.
// ----------------------------------------------------------------------------
module vrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pop,
    input logic       empty,
    input logic [7:0] frame_byte,
    input logic [4:0] byte_index,
    input logic       last
);
    import vrc_pkg::*;

    // last marks exactly the checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (byte_index == SUM_INDEX)))
        else $error("last flag disagrees with byte index");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (byte_index == HEADER_INDEX)) |-> (frame_byte == HEADER_BYTE))
        else $error("frame does not open with header byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (byte_index == FLAG_INDEX)) |-> (frame_byte == FLAG_BYTE))
        else $error("flag byte is not zero");

    // a waiting word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_index)))
        else $error("result word changed while stalled");

endmodule

bind velocity_to_rc_channel_frame vrc_checker u_vrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .empty      (empty),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last)
);

// ----- verif/velocity_to_rc_channel_frame_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_to_rc_channel_frame_tb
// Drives velocity and send words into the RC frame encoder and predicts the
// channel store and every 25-byte frame. Each popped frame word is compared
// field by field with the oldest predicted word. Both sides idle at random;
// one long receiver hold-off fills the block up. Registers are rewritten
// between phases, readback included.
// ----------------------------------------------------------------------------
module velocity_to_rc_channel_frame_tb;

    import vrc_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 48;
    localparam logic [2:0]  UNUSED_REG    = 3'd7;

    typedef struct {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic       last;
    } frame_word_t;

    typedef enum {
        POP_ALWAYS,
        POP_COIN,
        POP_PATTERN,
        POP_MOSTLY
    } pop_style_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_BITS-1:0]         paddr;
    logic [DATA_BITS-1:0]         pwdata;
    logic [DATA_BITS-1:0]         prdata;
    logic                         pready;
    logic                         push;
    logic                         full;
    logic                         cmd;
    logic signed [SPEED_BITS-1:0] linear_speed;
    logic signed [SPEED_BITS-1:0] turn_rate;
    logic                         pop;
    logic                         empty;
    logic [7:0]                   frame_byte;
    logic [4:0]                   byte_index;
    logic                         last;

    cfg_t               loaded_cfg;
    logic [CH_BITS-1:0] channel_values [CHANNEL_COUNT];
    frame_word_t        frame_words_due [$];
    int                 mismatch_count;
    int                 hold_off_cycles;
    int                 burst_left;
    bit                 sender_steady;

    velocity_to_rc_channel_frame dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .pop          (pop),
        .empty        (empty),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CH_BITS-1:0] speed_to_channel_value(
        input logic [31:0] raw,
        input logic [15:0] pos_gain,
        input logic [15:0] neg_gain
    );
        logic        negative;
        logic [31:0] magnitude;
        logic [47:0] product;
        longint      level;
        negative  = raw[31];
        magnitude = negative ? (32'd0 - raw) : raw;
        if (magnitude <= {16'd0, loaded_cfg.dead_band})
            return loaded_cfg.center;
        product = {16'd0, magnitude} * {32'd0, (negative ? neg_gain : pos_gain)};
        if (!negative)
        begin
            level = longint'(loaded_cfg.center) - longint'(product >> 16);
            if (level <= longint'(loaded_cfg.low_limit))
                return loaded_cfg.low_limit;
        end
        else
        begin
            level = longint'(loaded_cfg.center) + longint'(product >> 16);
            if (level >= longint'(loaded_cfg.high_limit))
                return loaded_cfg.high_limit;
        end
        return level[CH_BITS-1:0];
    endfunction

    function automatic void apply_command(
        input cmd_t        kind,
        input logic [31:0] lin,
        input logic [31:0] ang
    );
        logic [FRAME_BITS-1:0] packed_channels;
        logic [7:0]            sum;
        frame_word_t           word;
        if (kind == CMD_SET_VEL)
        begin
            channel_values[1] = speed_to_channel_value(lin, loaded_cfg.lin_gain,
                                                       loaded_cfg.lin_gain);
            channel_values[0] = speed_to_channel_value(ang, loaded_cfg.left_gain,
                                                       loaded_cfg.right_gain);
            return;
        end
        // channel 0 lands in the top bits, streamed MSB first
        for (int ch = 0; ch < CHANNEL_COUNT; ch++)
            packed_channels[FRAME_BITS-1-CH_BITS*ch -: CH_BITS] = channel_values[ch];
        sum = 8'd0;
        for (int b = 0; b <= SUM_INDEX; b++)
        begin
            if (b == HEADER_INDEX)
                word.frame_byte = HEADER_BYTE;
            else if (b <= DATA_LAST)
                word.frame_byte = packed_channels[FRAME_BITS-1-8*(b-1) -: 8];
            else if (b == FLAG_INDEX)
                word.frame_byte = FLAG_BYTE;
            else
                word.frame_byte = sum;
            sum             = sum + word.frame_byte;
            word.byte_index = b[4:0];
            word.last       = (b == SUM_INDEX);
            frame_words_due.push_back(word);
        end
    endfunction

    function automatic logic [31:0] random_speed();
        logic [31:0] mag;
        case ($urandom_range(0, 4))
            0:       mag = $urandom;
            1:       mag = {16'd0, loaded_cfg.dead_band} + $urandom_range(0, 2) - 1;
            2:       mag = $urandom_range(0, 4 * loaded_cfg.dead_band + 8);
            3:       mag = $urandom_range(0, 32'h0003_0000);
            default: mag = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        return ($urandom_range(0, 1) == 1) ? (32'd0 - mag) : mag;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] data;
        logic [31:0] readback;
        logic [31:0] stored;
        data = $urandom;
        if (idx <= REG_HIGH_LIMIT)
            data[10:0] = value[10:0];
        else
            data[15:0] = value;
        case (idx)
            REG_CENTER:     loaded_cfg.center     = data[10:0];
            REG_LOW_LIMIT:  loaded_cfg.low_limit  = data[10:0];
            REG_HIGH_LIMIT: loaded_cfg.high_limit = data[10:0];
            REG_LIN_GAIN:   loaded_cfg.lin_gain   = data[15:0];
            REG_LEFT_GAIN:  loaded_cfg.left_gain  = data[15:0];
            REG_RIGHT_GAIN: loaded_cfg.right_gain = data[15:0];
            REG_DEAD_BAND:  loaded_cfg.dead_band  = data[15:0];
            default:        ;
        endcase
        stored = (idx <= REG_HIGH_LIMIT) ? {21'd0, data[10:0]} : {16'd0, data[15:0]};

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx != UNUSED_REG)
        begin
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            readback = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            if (readback !== stored)
            begin
                $display("%0t: register %0d readback expected %0h actual %0h",
                         $time, idx, stored, readback);
                mismatch_count++;
            end
        end
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_CENTER,     {5'd0, c.center});
        write_reg(REG_LOW_LIMIT,  {5'd0, c.low_limit});
        write_reg(REG_HIGH_LIMIT, {5'd0, c.high_limit});
        write_reg(REG_LIN_GAIN,   c.lin_gain);
        write_reg(REG_LEFT_GAIN,  c.left_gain);
        write_reg(REG_RIGHT_GAIN, c.right_gain);
        write_reg(REG_DEAD_BAND,  c.dead_band);
        // unmapped address: must leave every register alone
        write_reg(UNUSED_REG, 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_word(input cmd_t kind, input logic [31:0] lin, input logic [31:0] ang);
        int gap;
        gap = 0;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 4);
                burst_left = $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        cmd          <= kind;
        linear_speed <= lin;
        turn_rate    <= ang;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_command(kind, lin, ang);
    endtask

    // drop push, drain every frame, then let queued set words retire
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Frame side
    // ------------------------------------------------------------------
    initial
    begin : drive_pop
        pop_style_t  style;
        int          span;
        logic [15:0] pattern;
        pop     <= 1'b0;
        style   = POP_ALWAYS;
        span    = 0;
        pattern = 16'hFFFF;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                style   = pop_style_t'($urandom_range(0, 3));
                span    = $urandom_range(20, 120);
                pattern = 16'($urandom) | 16'h0001;
            end
            span--;
            pattern = {pattern[0], pattern[15:1]};
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                pop <= 1'b0;
            end
            else
                case (style)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_COIN:    pop <= ($urandom_range(0, 1) == 1);
                    POP_PATTERN: pop <= pattern[0];
                    default:     pop <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin : check_frame_words
        frame_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (frame_words_due.size() == 0)
            begin
                $display("%0t: frame word with none expected: byte %02h index %0d last %0b",
                         $time, frame_byte, byte_index, last);
                mismatch_count++;
            end
            else
            begin
                want = frame_words_due.pop_front();
                if (frame_byte !== want.frame_byte)
                begin
                    $display("%0t: frame_byte expected %02h actual %02h (index %0d)",
                             $time, want.frame_byte, frame_byte, want.byte_index);
                    mismatch_count++;
                end
                if (byte_index !== want.byte_index)
                begin
                    $display("%0t: byte_index expected %0d actual %0d",
                             $time, want.byte_index, byte_index);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b (index %0d)",
                             $time, want.last, last, want.byte_index);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_frame();
        send_word(CMD_SEND, 32'd0, 32'd0);
    endtask

    task automatic test_speed_extremes();
        logic [31:0] lin_cases [9] = '{32'd0, 32'd65, 32'd66, -32'd66, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                                       32'd655};
        logic [31:0] ang_cases [9] = '{32'd0, -32'd65, -32'd66, 32'd66, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'hFFFF_0000, 32'd1, -32'd655};
        for (int n = 0; n < 9; n++)
        begin
            send_word(CMD_SET_VEL, lin_cases[n], ang_cases[n]);
            // speeds on a send word carry no meaning
            send_word(CMD_SEND, $urandom, $urandom);
        end
        settle();
    endtask

    task automatic test_config_sweep();
        cfg_t settings [4];
        settings[0] = '{center: 11'd0, low_limit: 11'd0, high_limit: 11'd0,
                        lin_gain: 16'd0, left_gain: 16'd0, right_gain: 16'd0,
                        dead_band: 16'd0};
        settings[1] = '{center: 11'd2047, low_limit: 11'd2047, high_limit: 11'd2047,
                        lin_gain: 16'hFFFF, left_gain: 16'hFFFF, right_gain: 16'hFFFF,
                        dead_band: 16'hFFFF};
        // low limit above center, high limit below it
        settings[2] = '{center: 11'd500, low_limit: 11'd1800, high_limit: 11'd200,
                        lin_gain: 16'd700, left_gain: 16'd3000, right_gain: 16'd9,
                        dead_band: 16'd0};
        settings[3] = '{center: 11'd1024, low_limit: 11'd1, high_limit: 11'd2046,
                        lin_gain: 16'd1, left_gain: 16'd250, right_gain: 16'd60000,
                        dead_band: 16'd3};
        for (int s = 0; s < 4; s++)
        begin
            apply_config(settings[s]);
            for (int n = 0; n < 10; n++)
                send_word(CMD_SET_VEL, random_speed(), random_speed());
            send_word(CMD_SEND, $urandom, $urandom);
            settle();
        end
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        for (int phase = 0; phase < 4; phase++)
        begin
            c.center     = $urandom_range(0, 2047);
            c.low_limit  = $urandom_range(0, c.center);
            c.high_limit = $urandom_range(c.center, 2047);
            if ($urandom_range(0, 3) == 0)
            begin
                c.low_limit  = $urandom_range(0, 2047);
                c.high_limit = $urandom_range(0, 2047);
            end
            c.lin_gain   = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            c.left_gain  = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            c.right_gain = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            c.dead_band  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
            apply_config(c);
            sender_steady = (phase == 2);
            for (int n = 0; n < 100; n++)
                if ($urandom_range(0, 9) < 3)
                    send_word(CMD_SEND, $urandom, $urandom);
                else
                    send_word(CMD_SET_VEL, random_speed(), random_speed());
            settle();
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_full_backpressure();
        sender_steady   = 1'b1;
        hold_off_cycles = 300;
        // keep offering words while the receiver holds off
        for (int n = 0; n < 14; n++)
            send_word((n % 3 == 0) ? CMD_SET_VEL : CMD_SEND, random_speed(), random_speed());
        settle();
        sender_steady = 1'b0;
    endtask

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("%0t: timeout after %0d cycles, %0d frame words still due",
                 $time, CYCLE_LIMIT, frame_words_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        push         <= 1'b0;
        cmd          <= CMD_SET_VEL;
        linear_speed <= '0;
        turn_rate    <= '0;

        loaded_cfg = '{center: CENTER_RESET, low_limit: LOW_RESET, high_limit: HIGH_RESET,
                       lin_gain: LIN_GAIN_RESET, left_gain: LEFT_GAIN_RESET,
                       right_gain: RIGHT_GAIN_RESET, dead_band: DEAD_BAND_RESET};
        for (int ch = 0; ch < CHANNEL_COUNT; ch++)
            channel_values[ch] = CHAN_RESET;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        burst_left      = 0;
        sender_steady   = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_speed_extremes();
        test_config_sweep();
        test_random_traffic();
        test_full_backpressure();

        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
